[design/fxalu_pkg.sv]
// ----------------------------------------------------------------------------
// fxalu_pkg: shared codes and types of the Q24.8 fixed-point ALU
// Operation codes, finish-path codes and the operation class record that
// the front hands to the back through the queue.
// ----------------------------------------------------------------------------
package fxalu_pkg;

  // operation codes
  localparam logic [3:0] MODE_ADD      = 4'd0;
  localparam logic [3:0] MODE_SUB      = 4'd1;
  localparam logic [3:0] MODE_MUL      = 4'd2;
  localparam logic [3:0] MODE_DIV      = 4'd3;
  localparam logic [3:0] MODE_GT       = 4'd4;
  localparam logic [3:0] MODE_LT       = 4'd5;
  localparam logic [3:0] MODE_GE       = 4'd6;
  localparam logic [3:0] MODE_LE       = 4'd7;
  localparam logic [3:0] MODE_EQ       = 4'd8;
  localparam logic [3:0] MODE_NE       = 4'd9;
  localparam logic [3:0] MODE_INC      = 4'd10;
  localparam logic [3:0] MODE_DEC      = 4'd11;
  localparam logic [3:0] MODE_MIN      = 4'd12;
  localparam logic [3:0] MODE_MAX      = 4'd13;
  localparam logic [3:0] MODE_TO_INT   = 4'd14;
  localparam logic [3:0] MODE_FROM_INT = 4'd15;

  // how the back finishes an item
  localparam logic [1:0] FIN_NONE = 2'd0;
  localparam logic [1:0] FIN_MUL  = 2'd1;
  localparam logic [1:0] FIN_DIV  = 2'd2;

  // operation class decided by the front
  typedef struct packed {
    logic addsub;
    logic mul;
    logic div;
    logic cmp;
    logic minmax;
    logic shr;
    logic shl;
  } op_class_t;

  localparam int CLS_BITS = $bits(op_class_t);

endpackage

[design/fxalu_front.sv]
// ----------------------------------------------------------------------------
// fxalu_front: item intake and classification
// Accepts an item when the queue has room and sorts the opcode into an
// operation class for the back.
// ----------------------------------------------------------------------------
module fxalu_front (
  input  logic                  start,
  input  logic                  q_full,
  input  logic [3:0]            in_mode,
  output logic                  busy,
  output logic                  push,
  output fxalu_pkg::op_class_t  cls
);
  import fxalu_pkg::*;

  assign busy = q_full;
  assign push = start && !q_full;

  // opcode decode
  always_comb begin
    cls = '0;
    case (in_mode) inside
      MODE_ADD, MODE_SUB, MODE_INC, MODE_DEC: cls.addsub = 1'b1;
      MODE_MUL:                               cls.mul    = 1'b1;
      MODE_DIV:                               cls.div    = 1'b1;
      [MODE_GT:MODE_NE]:                      cls.cmp    = 1'b1;
      MODE_MIN, MODE_MAX:                     cls.minmax = 1'b1;
      MODE_TO_INT:                            cls.shr    = 1'b1;
      MODE_FROM_INT:                          cls.shl    = 1'b1;
      default:                                cls        = '0;
    endcase
  end

endmodule

[design/fxalu_queue.sv]
// ----------------------------------------------------------------------------
// fxalu_queue: two-entry item queue between front and back
// Plain FIFO; the back drains one item per cycle whenever one is present.
// ----------------------------------------------------------------------------
module fxalu_queue #(
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] din,
  input  logic                 pop,
  output logic [DATA_BITS-1:0] dout,
  output logic                 not_empty,
  output logic                 full
);
  logic [DATA_BITS-1:0] mem_r [0:1];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           cnt_r, cnt_nxt;
  logic                 do_pop;

  assign not_empty = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign dout      = mem_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push   ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

[design/fxalu_back.sv]
// ----------------------------------------------------------------------------
// fxalu_back: execution pipeline
// Entry stage does add/sub, compare, min/max, shifts and operand magnitudes;
// then a restoring divider with one quotient bit per stage, a partial-product and
// quotient-rounding stage, a rounding/summing stage and a saturating output stage.
// ----------------------------------------------------------------------------
module fxalu_back #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  fxalu_pkg::op_class_t        cls,
  input  logic [3:0]                  mode,
  input  logic [WORD_BITS-1:0]        op_a,
  input  logic [WORD_BITS-1:0]        op_b,
  output logic                        out_valid,
  output logic signed [WORD_BITS-1:0] out_result_value,
  output logic                        out_compare_true,
  output logic                        out_overflow,
  output logic                        out_divide_by_zero
);
  import fxalu_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int NB = W + F;           // dividend / quotient bits
  localparam int DS = NB;              // divider stages
  localparam int H  = (W + 1) / 2;     // low half of a multiplier operand
  localparam int L  = W - H;           // high half
  localparam int MW = 2 * W + 1;       // magnitude width before saturation
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic [W-1:0] res;
    logic         cmp;
    logic         ov;
    logic         dz;
    logic [1:0]   fin;
    logic         neg;
    logic [W-1:0] ma;
  } pay_t;

  // ---------------- entry stage logic ----------------
  logic [W:0]   ea, eb, sum;
  logic         is_sub, sum_ov, lt, eq, cmpv, sh_ov, b_zero;
  logic [W-1:0] ma, mb, sh_res;
  logic [F:0]   a_top;
  pay_t         e_pl;

  always_comb begin
    ea     = {op_a[W-1], op_a};
    eb     = (mode == MODE_INC || mode == MODE_DEC) ? (W+1)'(1) : {op_b[W-1], op_b};
    is_sub = (mode == MODE_SUB || mode == MODE_DEC);
    sum    = is_sub ? (ea - eb) : (ea + eb);
    sum_ov = sum[W] ^ sum[W-1];
    lt     = $signed(op_a) < $signed(op_b);
    eq     = (op_a == op_b);
    ma     = op_a[W-1] ? (W'(0) - op_a) : op_a;
    mb     = op_b[W-1] ? (W'(0) - op_b) : op_b;
    b_zero = (op_b == '0);
    a_top  = op_a[W-1:W-1-F];
    sh_ov  = !((&a_top) || !(|a_top));
    sh_res = sh_ov ? (op_a[W-1] ? WMIN : WMAX) : (op_a << F);

    case (mode)
      MODE_GT: cmpv = !lt && !eq;
      MODE_LT: cmpv = lt;
      MODE_GE: cmpv = !lt;
      MODE_LE: cmpv = lt || eq;
      MODE_EQ: cmpv = eq;
      MODE_NE: cmpv = !eq;
      default: cmpv = 1'b0;
    endcase

    e_pl     = '0;
    e_pl.neg = op_a[W-1] ^ op_b[W-1];
    e_pl.ma  = ma;
    if (cls.addsub) begin
      e_pl.ov  = sum_ov;
      e_pl.res = sum_ov ? (sum[W] ? WMIN : WMAX) : sum[W-1:0];
    end else if (cls.mul) begin
      e_pl.fin = FIN_MUL;
    end else if (cls.div) begin
      if (b_zero) begin
        e_pl.dz  = 1'b1;
        e_pl.res = op_a[W-1] ? WMIN : WMAX;
      end else begin
        e_pl.fin = FIN_DIV;
      end
    end else if (cls.cmp) begin
      e_pl.cmp = cmpv;
    end else if (cls.minmax) begin
      e_pl.res = ((mode == MODE_MIN) == lt) ? op_a : op_b;
    end else if (cls.shr) begin
      e_pl.res = W'($signed(op_a) >>> F);
    end else if (cls.shl) begin
      e_pl.ov  = sh_ov;
      e_pl.res = sh_res;
    end
  end

  // ---------------- divider stage line ----------------
  logic           st_vld_r [0:DS];
  pay_t           st_pl_r  [0:DS];
  logic [W-1:0]   st_r_r   [0:DS];
  logic [NB-1:0]  st_q_r   [0:DS];
  logic [NB-1:0]  st_n_r   [0:DS];
  logic [W-1:0]   st_mb_r  [0:DS];

  // stage 0 captures the entry results and divider setup
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r[0] <= 1'b0;
    end else begin
      st_vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    st_pl_r[0] <= e_pl;
    st_r_r[0]  <= '0;
    st_q_r[0]  <= '0;
    st_n_r[0]  <= {ma, {F{1'b0}}};
    st_mb_r[0] <= mb;
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= DS; k++) begin : g_div
    logic [W:0] rr, rn;
    logic       ge;

    always_comb begin
      rr = {st_r_r[k-1], st_n_r[k-1][NB-1]};
      ge = rr >= {1'b0, st_mb_r[k-1]};
      rn = ge ? (rr - {1'b0, st_mb_r[k-1]}) : rr;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_vld_r[k] <= 1'b0;
      end else begin
        st_vld_r[k] <= st_vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      st_pl_r[k] <= st_pl_r[k-1];
      st_r_r[k]  <= rn[W-1:0];
      st_q_r[k]  <= {st_q_r[k-1][NB-2:0], ge};
      st_n_r[k]  <= {st_n_r[k-1][NB-2:0], 1'b0};
      st_mb_r[k] <= st_mb_r[k-1];
    end
  end

  // ---------------- partial products and quotient rounding ----------------
  logic            p_vld_r;
  pay_t            p_pl_r;
  logic [2*H-1:0]  p00_r;
  logic [H+L-1:0]  p01_r, p10_r;
  logic [2*L-1:0]  p11_r;
  logic [NB:0]     p_qx_r;
  logic            q_round;

  assign q_round = {st_r_r[DS], 1'b0} >= {1'b0, st_mb_r[DS]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= st_vld_r[DS];
    end
  end

  always_ff @(posedge clk) begin
    p_pl_r <= st_pl_r[DS];
    p00_r  <= st_pl_r[DS].ma[H-1:0] * st_mb_r[DS][H-1:0];
    p01_r  <= st_pl_r[DS].ma[H-1:0] * st_mb_r[DS][W-1:H];
    p10_r  <= st_pl_r[DS].ma[W-1:H] * st_mb_r[DS][H-1:0];
    p11_r  <= st_pl_r[DS].ma[W-1:H] * st_mb_r[DS][W-1:H];
    p_qx_r <= {1'b0, st_q_r[DS]} + (NB+1)'(q_round);
  end

  // ---------------- product sum and rounding ----------------
  logic          s_vld_r;
  pay_t          s_pl_r;
  logic [MW-1:0] s_mag_r;
  logic [MW-1:0] prod_rnd, mag_nxt;

  always_comb begin
    prod_rnd = MW'(p00_r) + (MW'(p01_r) << H) + (MW'(p10_r) << H)
             + (MW'(p11_r) << (2 * H)) + (MW'(1) << (F - 1));
    mag_nxt  = (p_pl_r.fin == FIN_DIV) ? MW'(p_qx_r) : (prod_rnd >> F);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else begin
      s_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s_pl_r  <= p_pl_r;
    s_mag_r <= mag_nxt;
  end

  // ---------------- saturation and output register ----------------
  logic          o_vld_r;
  logic [W-1:0]  o_res_r, o_res_nxt;
  logic          o_cmp_r, o_ov_r, o_ov_nxt, o_dz_r;
  logic [MW-1:0] limit;
  logic          big;

  always_comb begin
    limit     = s_pl_r.neg ? MW'(WMIN) : MW'(WMAX);
    big       = s_mag_r > limit;
    o_res_nxt = s_pl_r.res;
    o_ov_nxt  = s_pl_r.ov;
    if (s_pl_r.fin != FIN_NONE) begin
      o_ov_nxt = big;
      if (big) begin
        o_res_nxt = s_pl_r.neg ? WMIN : WMAX;
      end else begin
        o_res_nxt = s_pl_r.neg ? (W'(0) - s_mag_r[W-1:0]) : s_mag_r[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= s_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    o_res_r <= o_res_nxt;
    o_cmp_r <= s_pl_r.cmp;
    o_ov_r  <= o_ov_nxt;
    o_dz_r  <= s_pl_r.dz;
  end

  assign out_valid          = o_vld_r;
  assign out_result_value   = o_res_r;
  assign out_compare_true   = o_cmp_r;
  assign out_overflow       = o_ov_r;
  assign out_divide_by_zero = o_dz_r;

  // ---------------- assertions ----------------
  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    st_vld_r[0] && st_pl_r[0].fin == FIN_DIV |-> ##(DS+3) o_vld_r)
    else $error("divide item did not reach the output on time");

  a_dz_sat: assert property (@(posedge clk) disable iff (!rst_n)
    o_vld_r && o_dz_r |-> !o_ov_r && (o_res_r == WMAX || o_res_r == WMIN))
    else $error("divide by zero result not saturated or overflow set");

  a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    o_vld_r && o_cmp_r |-> !o_ov_r && !o_dz_r && o_res_r == '0)
    else $error("comparison result carries value or flags");

  a_ov_sat: assert property (@(posedge clk) disable iff (!rst_n)
    o_vld_r && o_ov_r |-> (o_res_r == WMAX || o_res_r == WMIN))
    else $error("overflow flagged on unsaturated result");

endmodule

[design/fixed_point_q24_8_alu.sv]
// Items go from the queue through stage 0, divider, product, sum and output stages.
// Throughput: one item per cycle; the divider has one stage per quotient bit.
// All operations share the same pipeline depth, so results leave in order.
// busy stays low: the back drains the queue every cycle; the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the queue and clears all valid bits.
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu: signed Q24.8 fixed-point ALU
// Front classifies items into a short queue; the back executes them in a
// fixed-depth pipeline with saturation; MUL and DIV round half away from zero.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [3:0]                  in_mode,
  input  logic signed [WORD_BITS-1:0] in_operand_a,
  input  logic signed [WORD_BITS-1:0] in_operand_b,
  output logic                        out_valid,
  output logic signed [WORD_BITS-1:0] out_result_value,
  output logic                        out_compare_true,
  output logic                        out_overflow,
  output logic                        out_divide_by_zero
);
  import fxalu_pkg::*;

  localparam int QB = CLS_BITS + 4 + 2 * WORD_BITS;

  logic                 push, q_full, q_vld;
  op_class_t            cls, h_cls;
  logic [QB-1:0]        q_din, q_dout;
  logic [3:0]           h_mode;
  logic [WORD_BITS-1:0] h_a, h_b;

  // intake
  fxalu_front u_front (
    .start   (start),
    .q_full  (q_full),
    .in_mode (in_mode),
    .busy    (busy),
    .push    (push),
    .cls     (cls)
  );

  // queue between front and back
  assign q_din = {cls, in_mode, in_operand_a, in_operand_b};

  fxalu_queue #(.DATA_BITS(QB)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (q_din),
    .pop       (1'b1),
    .dout      (q_dout),
    .not_empty (q_vld),
    .full      (q_full)
  );

  assign {h_cls, h_mode, h_a, h_b} = q_dout;

  // execution
  fxalu_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_vld             (q_vld),
    .cls                (h_cls),
    .mode               (h_mode),
    .op_a               (h_a),
    .op_b               (h_b),
    .out_valid          (out_valid),
    .out_result_value   (out_result_value),
    .out_compare_true   (out_compare_true),
    .out_overflow       (out_overflow),
    .out_divide_by_zero (out_divide_by_zero)
  );

endmodule
